// ===== hdl/cqstat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqstat_pkg
// Shared constants, operation and status codes, and the controller/datapath
// command and status structs of the circular queue statistics unit.
// ----------------------------------------------------------------------------
package cqstat_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef logic [1:0] func_t;
    typedef logic [1:0] status_t;

    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_REMOVE = 2'd1;
    localparam func_t FUNC_QUERY  = 2'd2;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic op;
        logic walk;
        logic div_start;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_done;
    } dp_sts_t;

endpackage

// ===== hdl/cqstat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqstat_ctrl
// Sequencer: accept, queue operation, ring walk, serial divide, result
// hand-off through the output register.
// ----------------------------------------------------------------------------
module cqstat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output cqstat_pkg::dp_cmd_t cmd,
    input  cqstat_pkg::dp_sts_t sts
);
    import cqstat_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_WALK,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = (state_reg == S_IDLE) && in_valid;
        cmd.op        = (state_reg == S_OP);
        cmd.walk      = (state_reg == S_WALK);
        cmd.div_start = (state_reg == S_WALK) && sts.walk_done;
        cmd.div_step  = (state_reg == S_DIV);
        cmd.out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/cqstat_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqstat_datapath
// Ring storage with head/tail/count, a one-entry-per-cycle walk that keeps
// max, min, sum and key match, a restoring divider for the Q8 mean, and the
// result registers.
// ----------------------------------------------------------------------------
module cqstat_datapath #(
    parameter int DEPTH      = cqstat_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = cqstat_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cqstat_pkg::dp_cmd_t           cmd,
    output cqstat_pkg::dp_sts_t           sts,
    input  cqstat_pkg::func_t             func,
    input  logic signed [DATA_WIDTH-1:0]  value,
    output cqstat_pkg::status_t           status,
    output logic [$clog2(DEPTH)-1:0]      count,
    output logic signed [DATA_WIDTH-1:0]  largest,
    output logic signed [DATA_WIDTH-1:0]  smallest,
    output logic signed [DATA_WIDTH+7:0]  mean_q8,
    output logic                          found
);
    import cqstat_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH);
    localparam int SUM_W  = DATA_WIDTH + CNT_W;
    localparam int DIV_W  = SUM_W + 8;
    localparam int MEAN_W = DATA_WIDTH + 8;
    localparam int DL_W   = $clog2(DIV_W + 1);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(DEPTH - 1);

    function automatic logic [CNT_W-1:0] next_slot(input logic [CNT_W-1:0] i);
        next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    logic [DATA_WIDTH-1:0]        mem [DEPTH];

    func_t                        func_reg;
    logic signed [DATA_WIDTH-1:0] key_reg;

    logic [CNT_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    status_t                      op_status_reg, op_status_next;
    logic                         wr_en;

    logic [CNT_W-1:0]             ptr_reg;
    logic [CNT_W-1:0]             left_reg;
    logic                         rd_valid_reg;
    logic                         rd_en;
    logic signed [DATA_WIDTH-1:0] rd_data_reg;
    logic                         seen_reg;
    logic signed [DATA_WIDTH-1:0] big_reg;
    logic signed [DATA_WIDTH-1:0] small_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SUM_W-1:0]      elem_ext;
    logic                         found_reg;

    logic [SUM_W-1:0]             sum_mag;
    logic [DIV_W-1:0]             quo_reg;
    logic [CNT_W-1:0]             rem_reg;
    logic [CNT_W:0]               rem_sh;
    logic                         qbit;
    logic                         neg_reg;
    logic [DL_W-1:0]              div_left_reg;
    logic [MEAN_W-1:0]            q_mag;
    logic signed [MEAN_W-1:0]     mean_next;

    status_t                      status_reg;
    logic [CNT_W-1:0]             count_reg;
    logic signed [DATA_WIDTH-1:0] largest_reg;
    logic signed [DATA_WIDTH-1:0] smallest_reg;
    logic signed [MEAN_W-1:0]     mean_reg;
    logic                         found_out_reg;

    // queue operation
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        op_status_next = ST_DONE;
        wr_en          = 1'b0;
        case (func_reg)
            FUNC_INSERT:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    op_status_next = ST_FULL;
                end
                else
                begin
                    wr_en     = cmd.op;
                    tail_next = next_slot(tail_reg);
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (cnt_reg == '0)
                begin
                    op_status_next = ST_EMPTY;
                end
                else
                begin
                    head_next = next_slot(head_reg);
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                if (cnt_reg == '0)
                begin
                    op_status_next = ST_EMPTY;
                end
            end
            default:
            begin
                op_status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.op)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // storage
    assign rd_en = cmd.walk && (left_reg != '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            key_reg  <= value;
        end
    end

    // walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            left_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.op)
        begin
            ptr_reg      <= head_next;
            left_reg     <= cnt_next;
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.walk)
        begin
            rd_valid_reg <= rd_en;
            if (rd_en)
            begin
                ptr_reg  <= next_slot(ptr_reg);
                left_reg <= left_reg - 1'b1;
            end
        end
    end

    assign elem_ext = {{CNT_W{rd_data_reg[DATA_WIDTH-1]}}, rd_data_reg};

    // accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.op)
        begin
            op_status_reg <= op_status_next;
            seen_reg      <= 1'b0;
            big_reg       <= '0;
            small_reg     <= '0;
            sum_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else if (cmd.walk && rd_valid_reg)
        begin
            seen_reg <= 1'b1;
            if (!seen_reg || (rd_data_reg > big_reg))
            begin
                big_reg <= rd_data_reg;
            end
            if (!seen_reg || (rd_data_reg < small_reg))
            begin
                small_reg <= rd_data_reg;
            end
            sum_reg <= sum_reg + elem_ext;
            if ((func_reg == FUNC_QUERY) && (rd_data_reg == key_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign qbit    = (rem_sh >= {1'b0, cnt_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_left_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_left_reg <= DL_W'(DIV_W);
        end
        else if (cmd.div_step && (div_left_reg != '0))
        begin
            div_left_reg <= div_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= {sum_mag, 8'd0};
            rem_reg <= '0;
            neg_reg <= sum_reg[SUM_W-1];
        end
        else if (cmd.div_step && (div_left_reg != '0))
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], qbit};
            rem_reg <= qbit ? CNT_W'(rem_sh - {1'b0, cnt_reg}) : rem_sh[CNT_W-1:0];
        end
    end

    assign q_mag     = quo_reg[MEAN_W-1:0];
    assign mean_next = (cnt_reg == '0) ? '0 :
                       neg_reg ? MEAN_W'(-q_mag) : MEAN_W'(q_mag);

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg    <= op_status_reg;
            count_reg     <= cnt_reg;
            largest_reg   <= big_reg;
            smallest_reg  <= small_reg;
            mean_reg      <= mean_next;
            found_out_reg <= found_reg;
        end
    end

    assign sts.walk_done = (left_reg == '0) && !rd_valid_reg;
    assign sts.div_done  = (div_left_reg == '0);

    assign status   = status_reg;
    assign count    = count_reg;
    assign largest  = largest_reg;
    assign smallest = smallest_reg;
    assign mean_q8  = mean_reg;
    assign found    = found_out_reg;

endmodule

// ===== hdl/circular_queue_with_statistics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_statistics_unit
// Ring FIFO of signed words holding DEPTH-1 entries; a transaction inserts,
// removes or queries (any other func code leaves the queue as it is), then
// reports count, max, min, Q8 mean and key match over the contents.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   in       | in_valid, in_ready, func, value  | to unit
//   out      | out_valid, out_ready, status,    | from unit
//            | count, largest, smallest,        |
//            | mean_q8, found                   |
//
// From acceptance to result an item passes the queue operation, a walk
// through the single-port storage that reads one entry per cycle over the
// N entries held after the operation, and the divider, which yields one
// quotient bit per cycle.
// One item is in flight at a time; the result register lets the next item
// be accepted while the previous result waits on out_ready.
// Reset empties the queue; storage contents are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_statistics_unit #(
    parameter int DEPTH      = cqstat_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = cqstat_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cqstat_pkg::func_t             func,
    input  logic signed [DATA_WIDTH-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cqstat_pkg::status_t           status,
    output logic [$clog2(DEPTH)-1:0]      count,
    output logic signed [DATA_WIDTH-1:0]  largest,
    output logic signed [DATA_WIDTH-1:0]  smallest,
    output logic signed [DATA_WIDTH+7:0]  mean_q8,
    output logic                          found
);
    import cqstat_pkg::*;

    localparam int CNT_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(DEPTH - 1);

    dp_cmd_t cmd;
    dp_sts_t sts;

    cqstat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    cqstat_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .func     (func),
        .value    (value),
        .status   (status),
        .count    (count),
        .largest  (largest),
        .smallest (smallest),
        .mean_q8  (mean_q8),
        .found    (found)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while one is in flight");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (count == MAX_COUNT))
        else $error("full status with queue not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> ((count == '0) && !found))
        else $error("empty status with entries held or key found");

    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (count == '0)) |->
            ((largest == '0) && (smallest == '0) && (mean_q8 == '0) && !found))
        else $error("nonzero statistics on empty queue");

endmodule
